// File: rtl/omwpm_pkg.sv
// ----------------------------------------------------------------------------
// omwpm_pkg
// Shared widths, constants, register indexes and the divider sideband word
// for the omni-wheel power mixer.
// ----------------------------------------------------------------------------
package omwpm_pkg;

  // field and datapath widths
  localparam int ANG_W  = 16;   // binary angle
  localparam int SIN_W  = 15;   // Q14 sine magnitude, 0..16384
  localparam int NUM_W  = 23;   // |sine| * speed
  localparam int QUO_W  = 24;   // scaled power, Q16, below 256 << 16
  localparam int CORR_W = 32;   // heading correction, Q16

  // configuration register indexes
  localparam logic [2:0] REG_ANGLE_A = 3'd0;
  localparam logic [2:0] REG_ANGLE_B = 3'd1;
  localparam logic [2:0] REG_ANGLE_C = 3'd2;
  localparam logic [2:0] REG_ANGLE_D = 3'd3;
  localparam logic [2:0] REG_GAIN    = 3'd4;

  // register reset values
  localparam logic [ANG_W-1:0] ANGLE_A_RST = 16'd8192;
  localparam logic [ANG_W-1:0] ANGLE_B_RST = 16'd24576;
  localparam logic [ANG_W-1:0] ANGLE_C_RST = 16'd40960;
  localparam logic [ANG_W-1:0] ANGLE_D_RST = 16'd57344;

  // sine polynomial coefficients, Q14
  localparam logic [SIN_W-1:0] SIN_A = 15'd25736;
  localparam logic [SIN_W-1:0] SIN_B = 15'd10512;
  localparam logic [SIN_W-1:0] SIN_C = 15'd1160;

  // power limit in Q16 and duty center
  localparam logic signed [32:0] POWER_LIM_Q16 = 33'sd16711680;
  localparam logic signed [8:0]  POWER_MAX     = 9'sd255;
  localparam logic [8:0]         DUTY_CENTER   = 9'd256;

  // per-wheel word that rides along the divider pipeline
  typedef struct packed {
    logic                     neg;
    logic                     zero;
    logic signed [CORR_W-1:0] corr;
    logic [1:0]               idx;
    logic                     last;
  } div_side_t;

endpackage

// File: rtl/omwpm_sine_lane.sv
// ----------------------------------------------------------------------------
// omwpm_sine_lane
// Five-stage Q14 sine magnitude of one wheel's angle difference: fold,
// square, then the three multiply steps of the odd polynomial.
// ----------------------------------------------------------------------------
module omwpm_sine_lane
  import omwpm_pkg::*;
(
  input  logic             clk,
  input  logic [ANG_W-1:0] diff,
  output logic [SIN_W-1:0] mag,
  output logic             neg
);

  logic [SIN_W-1:0] z1_r, z1_nxt;
  logic             neg1_r, neg1_nxt;
  logic [SIN_W-1:0] z2_r, z2_nxt, za2_r;
  logic             neg2_r;
  logic [SIN_W-1:0] y1_r, y1_nxt, z2b_r, za3_r;
  logic             neg3_r;
  logic [SIN_W-1:0] y3_r, y3_nxt, za4_r;
  logic             neg4_r;
  logic [SIN_W-1:0] mag_r, mag_nxt;
  logic             neg5_r;
  logic [29:0]      p2, p3, p4, p5;

  // fold the signed angle into a quarter turn
  always_comb begin
    logic signed [17:0] s;
    logic signed [17:0] f;
    s = 18'($signed(diff));
    if (s > 18'sd16384) begin
      f = 18'sd32768 - s;
    end else if (s < -18'sd16384) begin
      f = -18'sd32768 - s;
    end else begin
      f = s;
    end
    neg1_nxt = f[17];
    z1_nxt   = f[17] ? SIN_W'(-f) : SIN_W'(f);
  end

  // polynomial steps, one multiplier per stage
  assign p2      = 30'(z1_r) * 30'(z1_r);
  assign z2_nxt  = p2[28:14];
  assign p3      = 30'(SIN_C) * 30'(z2_r);
  assign y1_nxt  = SIN_B - SIN_W'(p3[25:14]);
  assign p4      = 30'(y1_r) * 30'(z2b_r);
  assign y3_nxt  = SIN_A - p4[28:14];
  assign p5      = 30'(y3_r) * 30'(za4_r);
  assign mag_nxt = p5[28:14];

  always_ff @(posedge clk) begin
    z1_r   <= z1_nxt;
    neg1_r <= neg1_nxt;
    z2_r   <= z2_nxt;
    za2_r  <= z1_r;
    neg2_r <= neg1_r;
    y1_r   <= y1_nxt;
    z2b_r  <= z2_r;
    za3_r  <= za2_r;
    neg3_r <= neg2_r;
    y3_r   <= y3_nxt;
    za4_r  <= za3_r;
    neg4_r <= neg3_r;
    mag_r  <= mag_nxt;
    neg5_r <= neg4_r;
  end

  assign mag = mag_r;
  assign neg = neg5_r;

endmodule

// File: rtl/omwpm_div.sv
// ----------------------------------------------------------------------------
// omwpm_div
// Pipelined restoring divider: (num << 16) / den, with num < den << 8.
// Four quotient bits per stage, one word may enter every cycle.
// ----------------------------------------------------------------------------
module omwpm_div
  import omwpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [SIN_W-1:0] in_den,
  input  div_side_t        in_side,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output div_side_t        out_side
);

  localparam int STEPS  = 4;
  localparam int STAGES = QUO_W / STEPS;

  logic             v_r    [STAGES+1];
  logic [SIN_W-1:0] rem_r  [STAGES+1];
  logic [QUO_W-1:0] shf_r  [STAGES+1];
  logic [QUO_W-1:0] quo_r  [STAGES+1];
  logic [SIN_W-1:0] den_r  [STAGES+1];
  div_side_t        side_r [STAGES+1];

  logic [SIN_W-1:0] rem_nxt [STAGES];
  logic [QUO_W-1:0] shf_nxt [STAGES];
  logic [QUO_W-1:0] quo_nxt [STAGES];

  // compare-subtract steps of every stage
  always_comb begin
    logic [SIN_W-1:0] rem;
    logic [QUO_W-1:0] shf;
    logic [QUO_W-1:0] quo;
    logic [SIN_W:0]   r2;
    for (int k = 0; k < STAGES; k++) begin
      rem = rem_r[k];
      shf = shf_r[k];
      quo = quo_r[k];
      for (int j = 0; j < STEPS; j++) begin
        r2  = {rem, shf[QUO_W-1]};
        shf = {shf[QUO_W-2:0], 1'b0};
        if (r2 >= {1'b0, den_r[k]}) begin
          rem = SIN_W'(r2 - {1'b0, den_r[k]});
          quo = {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem = r2[SIN_W-1:0];
          quo = {quo[QUO_W-2:0], 1'b0};
        end
      end
      rem_nxt[k] = rem;
      shf_nxt[k] = shf;
      quo_nxt[k] = quo;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= STAGES; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int k = 0; k < STAGES; k++) v_r[k+1] <= v_r[k];
    end
  end

  // payload; the integer part of num sits in the remainder from the start
  always_ff @(posedge clk) begin
    rem_r[0]  <= in_num[NUM_W-1:8];
    shf_r[0]  <= {in_num[7:0], 16'd0};
    quo_r[0]  <= '0;
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
    for (int k = 0; k < STAGES; k++) begin
      rem_r[k+1]  <= rem_nxt[k];
      shf_r[k+1]  <= shf_nxt[k];
      quo_r[k+1]  <= quo_nxt[k];
      den_r[k+1]  <= den_r[k];
      side_r[k+1] <= side_r[k];
    end
  end

  assign out_valid = v_r[STAGES];
  assign out_quo   = quo_r[STAGES];
  assign out_side  = side_r[STAGES];

endmodule

// File: rtl/omni_wheel_power_mixer_top.sv
// ----------------------------------------------------------------------------
// omni_wheel_power_mixer_top
// Mixes a travel command into one drive power and antiphase duty per wheel.
//
//   channel  ports                                 handshake
//   input    in_travel_angle, in_heading, in_speed start high, busy low
//   result   out_wheel_index/power/duty, out_last  out_valid, one cycle
//   config   cfg_index, cfg_data                   cfg_we
//
// A command yields WHEEL_COUNT words on consecutive cycles, wheel 0 first.
// busy is raised after each command is taken, as the single divider
// pipeline takes one wheel per cycle; start is not taken while busy is high.
// Reset is synchronous and loads the default mounting angles, gain zero.
// Results are never held back; there is no stall path.
// ----------------------------------------------------------------------------
module omni_wheel_power_mixer_top
  import omwpm_pkg::*;
#(
  parameter int WHEEL_COUNT = 4
)(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [ANG_W-1:0]        in_travel_angle,
  input  logic signed [ANG_W-1:0] in_heading,
  input  logic [7:0]              in_speed,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [ANG_W-1:0]        cfg_data,
  output logic                    out_valid,
  output logic [1:0]              out_wheel_index,
  output logic signed [8:0]       out_wheel_power,
  output logic [8:0]              out_wheel_duty,
  output logic                    out_last_wheel
);

  localparam int CNT_W = $clog2(WHEEL_COUNT);
  localparam int LAT   = 5;

  logic [ANG_W-1:0] angle_r [4];
  logic [ANG_W-1:0] gain_r;
  logic             accept;
  logic [CNT_W-1:0] busy_cnt_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r[0] <= ANGLE_A_RST;
      angle_r[1] <= ANGLE_B_RST;
      angle_r[2] <= ANGLE_C_RST;
      angle_r[3] <= ANGLE_D_RST;
      gain_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE_A: angle_r[0] <= cfg_data;
        REG_ANGLE_B: angle_r[1] <= cfg_data;
        REG_ANGLE_C: angle_r[2] <= cfg_data;
        REG_ANGLE_D: angle_r[3] <= cfg_data;
        REG_GAIN:    gain_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // command acceptance pacing
  assign accept = start && !busy;
  assign busy   = (busy_cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_cnt_r <= '0;
    end else if (accept) begin
      busy_cnt_r <= CNT_W'(WHEEL_COUNT - 1);
    end else if (busy) begin
      busy_cnt_r <= busy_cnt_r - 1'b1;
    end
  end

  // entry stage: angle differences
  logic                    v1_r;
  logic [ANG_W-1:0]        diff_r [WHEEL_COUNT];
  logic signed [ANG_W-1:0] head_r;
  logic [7:0]              spd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= accept;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      diff_r[i] <= in_travel_angle - angle_r[i];
    end
    head_r <= in_heading;
    spd1_r <= in_speed;
  end

  // sine lanes
  logic [SIN_W-1:0] mag  [WHEEL_COUNT];
  logic             sneg [WHEEL_COUNT];

  for (genvar g = 0; g < WHEEL_COUNT; g++) begin : g_lane
    omwpm_sine_lane u_lane (
      .clk  (clk),
      .diff (diff_r[g]),
      .mag  (mag[g]),
      .neg  (sneg[g])
    );
  end

  // heading correction and sideband alongside the lanes
  logic                     vs_r   [LAT];
  logic signed [CORR_W-1:0] corr_r [LAT];
  logic [7:0]               spd_r  [LAT];
  logic signed [CORR_W-1:0] corr_nxt;
  logic signed [16:0]       head_neg;

  assign head_neg = -17'(head_r);
  assign corr_nxt = CORR_W'(head_neg) * CORR_W'($signed({1'b0, gain_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vs_r[k] <= 1'b0;
    end else begin
      vs_r[0] <= v1_r;
      for (int k = 1; k < LAT; k++) vs_r[k] <= vs_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    corr_r[0] <= corr_nxt;
    spd_r[0]  <= spd1_r;
    for (int k = 1; k < LAT; k++) begin
      corr_r[k] <= corr_r[k-1];
      spd_r[k]  <= spd_r[k-1];
    end
  end

  // largest magnitude and numerators
  logic [SIN_W-1:0] max_nxt;
  logic [NUM_W-1:0] num_nxt [WHEEL_COUNT];

  always_comb begin
    max_nxt = '0;
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      if (mag[i] > max_nxt) max_nxt = mag[i];
      num_nxt[i] = NUM_W'(mag[i]) * NUM_W'(spd_r[LAT-1]);
    end
  end

  // serializer: one wheel per cycle into the divider
  logic [NUM_W-1:0]         num_r [WHEEL_COUNT];
  logic                     ng_r  [WHEEL_COUNT];
  logic [SIN_W-1:0]         max_r;
  logic signed [CORR_W-1:0] corr_s_r;
  logic                     active_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     cnt_last;
  div_side_t                issue_side;

  assign cnt_last = (cnt_r == CNT_W'(WHEEL_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (vs_r[LAT-1]) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else if (active_r) begin
      if (cnt_last) begin
        active_r <= 1'b0;
        cnt_r    <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vs_r[LAT-1]) begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        num_r[i] <= num_nxt[i];
        ng_r[i]  <= sneg[i];
      end
      max_r    <= max_nxt;
      corr_s_r <= corr_r[LAT-1];
    end
  end

  assign issue_side.neg  = ng_r[cnt_r];
  assign issue_side.zero = (max_r == '0);
  assign issue_side.corr = corr_s_r;
  assign issue_side.idx  = 2'(cnt_r);
  assign issue_side.last = cnt_last;

  // divider pipeline
  logic             dv;
  logic [QUO_W-1:0] quo;
  div_side_t        dside;

  omwpm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (active_r),
    .in_num    (num_r[cnt_r]),
    .in_den    ((max_r == '0) ? SIN_W'(1) : max_r),
    .in_side   (issue_side),
    .out_valid (dv),
    .out_quo   (quo),
    .out_side  (dside)
  );

  // add correction
  logic                fv_r;
  logic signed [32:0]  sum_r;
  logic [1:0]          fidx_r;
  logic                flast_r;
  logic signed [QUO_W:0] scaled;

  always_comb begin
    if (dside.zero)     scaled = '0;
    else if (dside.neg) scaled = -$signed({1'b0, quo});
    else                scaled = $signed({1'b0, quo});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fv_r <= 1'b0;
    else        fv_r <= dv;
  end

  always_ff @(posedge clk) begin
    sum_r   <= 33'(scaled) + 33'(dside.corr);
    fidx_r  <= dside.idx;
    flast_r <= dside.last;
  end

  // clamp, truncate toward zero, duty
  logic signed [8:0] pw_nxt;
  logic signed [32:0] sum_adj;

  assign sum_adj = sum_r + 33'sd65535;

  always_comb begin
    if (sum_r > POWER_LIM_Q16) begin
      pw_nxt = POWER_MAX;
    end else if (sum_r < -POWER_LIM_Q16) begin
      pw_nxt = -POWER_MAX;
    end else if (sum_r < 33'sd0) begin
      pw_nxt = 9'(sum_adj >>> 16);
    end else begin
      pw_nxt = 9'(sum_r >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= fv_r;
  end

  always_ff @(posedge clk) begin
    out_wheel_index <= fidx_r;
    out_wheel_power <= pw_nxt;
    out_wheel_duty  <= DUTY_CENTER - pw_nxt;
    out_last_wheel  <= flast_r;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after a command");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_wheel) |-> (out_wheel_index == 2'(WHEEL_COUNT - 1)))
    else $error("last word on the wrong wheel");

  a_words_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_wheel) |=> out_valid)
    else $error("gap inside a command's words");

  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_wheel_power != -9'sd256))
    else $error("power outside the limit");

  a_duty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (9'(out_wheel_duty + out_wheel_power) == DUTY_CENTER))
    else $error("duty does not match power");
`endif

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the omni-wheel power mixer: commands are driven
// in bursts, each accepted command is run through a local fixed-point model
// of the wheel mix, and every result word is checked against it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import omwpm_pkg::*;

  localparam int WHEELS    = 4;
  localparam int DRAIN_CYC = 40;
  localparam int WD_LIMIT  = 2000;

  typedef struct packed {
    logic [15:0]        travel;
    logic signed [15:0] heading;
    logic [7:0]         speed;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        idx;
    logic signed [8:0] power;
    logic [8:0]        duty;
    logic              last;
  } wheel_word_t;

  logic clk, rst_n, start, busy, cfg_we;
  logic [15:0] in_travel_angle, cfg_data;
  logic signed [15:0] in_heading;
  logic [7:0] in_speed;
  logic [2:0] cfg_index;
  logic out_valid, out_last_wheel;
  logic [1:0] out_wheel_index;
  logic signed [8:0] out_wheel_power;
  logic [8:0] out_wheel_duty;

  omni_wheel_power_mixer_top #(.WHEEL_COUNT(WHEELS)) dut (.*);

  // local copy of the register file
  logic [15:0] mount_ang [4];
  logic [15:0] gain;

  cmd_t        cmd_q[$];
  wheel_word_t wheel_exp_q[$];
  int  errors = 0;
  int  idle_cyc = 0;
  int  burst_left = 0, gap_left = 0;

  // sampled handshake of the previous rising edge
  logic busy_s, took;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Q14 sine, polynomial on the folded angle
  function automatic int sine_q14(logic [15:0] ang);
    int s, z, z2, y;
    s = $signed(ang);
    if (s > 16384) s = 32768 - s;
    else if (s < -16384) s = -32768 - s;
    z = (s < 0) ? -s : s;
    z2 = (z * z) >>> 14;
    y = (1160 * z2) >>> 14;
    y = 10512 - y;
    y = (y * z2) >>> 14;
    y = 25736 - y;
    y = (y * z) >>> 14;
    return (s < 0) ? -y : y;
  endfunction

  // expected wheel words for one command
  task automatic mix_wheels(cmd_t c);
    int sn [4];
    int maxmag, mag;
    longint corr, scaled, sum, lim, pw;
    wheel_word_t w;
    maxmag = 0;
    for (int i = 0; i < WHEELS; i++) begin
      sn[i] = sine_q14(c.travel - mount_ang[i]);
      mag = sn[i] < 0 ? -sn[i] : sn[i];
      if (mag > maxmag) maxmag = mag;
    end
    corr = -(longint'(c.heading) * longint'(gain));
    lim = 255 * 65536;
    for (int i = 0; i < WHEELS; i++) begin
      scaled = 0;
      if (maxmag > 0) begin
        mag = sn[i] < 0 ? -sn[i] : sn[i];
        scaled = ((longint'(mag) * c.speed) << 16) / maxmag;
        if (sn[i] < 0) scaled = -scaled;
      end
      sum = scaled + corr;
      if (sum > lim) sum = lim;
      if (sum < -lim) sum = -lim;
      pw = sum / 65536;
      w.idx = i[1:0];
      w.power = pw[8:0];
      w.duty = 9'(256 - pw);
      w.last = (i == WHEELS - 1);
      wheel_exp_q.push_back(w);
    end
  endtask

  // driver: bursts of commands with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_travel_angle <= '0;
      in_heading <= '0;
      in_speed <= '0;
    end else if (start && !busy_s) begin
      start <= 0;
      if (burst_left > 0) burst_left <= burst_left - 1;
      else begin
        burst_left <= $urandom_range(0, 8);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else if (!start) begin
      if (cmd_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else begin
          {in_travel_angle, in_heading, in_speed} <= cmd_q[0];
          start <= 1;
        end
      end
    end
  end

  // accepted commands go to the model
  always @(posedge clk) begin
    took = rst_n && start && !busy;
    busy_s <= busy;
    if (took) mix_wheels(cmd_q.pop_front());
  end

  // monitor and watchdog
  always @(posedge clk) begin
    wheel_word_t e;
    if (rst_n) begin
      if (out_valid) begin
        if (wheel_exp_q.size() == 0) begin
          $display("%0t: unexpected word idx=%0d power=%0d", $time, out_wheel_index,
                   out_wheel_power);
          errors++;
        end else begin
          e = wheel_exp_q.pop_front();
          if (out_wheel_index !== e.idx) begin
            $display("%0t: index exp %0d got %0d", $time, e.idx, out_wheel_index);
            errors++;
          end
          if (out_wheel_power !== e.power) begin
            $display("%0t: power exp %0d got %0d", $time, e.power, out_wheel_power);
            errors++;
          end
          if (out_wheel_duty !== e.duty) begin
            $display("%0t: duty exp %0d got %0d", $time, e.duty, out_wheel_duty);
            errors++;
          end
          if (out_last_wheel !== e.last) begin
            $display("%0t: last exp %0d got %0d", $time, e.last, out_last_wheel);
            errors++;
          end
        end
      end
      if (out_valid || (start && !busy)) idle_cyc <= 0;
      else if (cmd_q.size() > 0 || wheel_exp_q.size() > 0) idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= WD_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.travel = 16'($urandom);
    c.heading = 16'($urandom);
    c.speed = 8'($urandom);
    if ($urandom_range(0, 5) == 0) c.heading = 16'($urandom_range(0, 8) - 4);
    return c;
  endfunction

  task automatic wait_drain();
    while (cmd_q.size() > 0 || wheel_exp_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
    if (idx <= REG_ANGLE_D) mount_ang[idx[1:0]] = val;
    else if (idx == REG_GAIN) gain = val;
  endtask

  initial begin
    logic [15:0] g;
    rst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    mount_ang = '{ANGLE_A_RST, ANGLE_B_RST, ANGLE_C_RST, ANGLE_D_RST};
    gain = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: field extremes, default gain
    cmd_q.push_back('{16'd0, 16'sd0, 8'd255});
    cmd_q.push_back('{16'hFFFF, -16'sd32768, 8'd0});
    cmd_q.push_back('{16'h8000, 16'sd32767, 8'd255});
    cmd_q.push_back('{16'h2000, 16'sd0, 8'd1});
    cmd_q.push_back('{16'h4000, -16'sd1, 8'd128});
    cmd_q.push_back('{16'hC000, 16'sd1, 8'd200});
    wait_drain();

    // all mounts equal: every sine is zero for travel 16'h1234 and its opposite
    for (int i = 0; i < 4; i++) write_reg(i[2:0], 16'h1234);
    write_reg(REG_GAIN, 16'hFFFF);
    write_reg(3'd7, 16'hABCD);
    cmd_q.push_back('{16'h1234, -16'sd32768, 8'd255});
    cmd_q.push_back('{16'h1234, 16'sd32767, 8'd9});
    cmd_q.push_back('{16'h9234, 16'sd3, 8'd50});
    cmd_q.push_back('{16'h5234, -16'sd2, 8'd77});
    wait_drain();

    // random phases across register settings, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 4; i++)
        write_reg(i[2:0], (ph == 1) ? 16'h0000 : (ph == 2) ? 16'hFFFF : 16'($urandom));
      g = (ph == 0) ? 16'd0 : (ph == 2) ? 16'hFFFF : (ph == 3) ? 16'd1 :
          16'($urandom_range(0, 600));
      write_reg(REG_GAIN, g);
      for (int k = 0; k < 42; k++) cmd_q.push_back(rand_cmd());
      wait_drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/omwpm_pkg.sv
rtl/omwpm_sine_lane.sv
rtl/omwpm_div.sv
rtl/omni_wheel_power_mixer_top.sv
test/tb_top.sv
